### design/assert_macros.svh
// Assertion macros used by the gate's top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

### design/rffag_pkg.sv
// Types and constants of the redundant-feed first-arrival gate.
package rffag_pkg;
    localparam logic [2:0] DISP_REJECT   = 3'd0;
    localparam logic [2:0] DISP_FIRST    = 3'd1;
    localparam logic [2:0] DISP_STALE    = 3'd2;
    localparam logic [2:0] DISP_CONFLICT = 3'd3;
    localparam logic [2:0] DISP_DUP      = 3'd4;
    localparam logic [2:0] DISP_CONFIRM  = 3'd5;

    localparam logic [1:0] LANE_BAD     = 2'd3;
    localparam logic [1:0] CONFIRM_MAX  = 2'd2;
    localparam logic [7:0] SIDE_BUY     = 8'h01;
    localparam logic [7:0] SIDE_SELL    = 8'hFF;
    localparam logic [2:0] HEALTH_OK    = 3'b100;

    localparam logic REG_VENUE = 1'b0;
    localparam logic REG_KIND  = 1'b1;

    typedef struct packed {
        logic        used;
        logic [63:0] seq;
        logic [31:0] asset;
        logic [63:0] xtime;
        logic [63:0] ftime;
        logic [63:0] price;
        logic [63:0] size;
        logic [7:0]  side;
        logic [2:0]  lanes;
        logic [1:0]  confirms;
        logic        conflict;
    } slot_t;

    typedef struct packed {
        logic [2:0]  disposition;
        logic [63:0] out_sequence;
        logic [63:0] first_time;
        logic [63:0] confirm_time;
        logic [2:0]  lanes_seen;
        logic [1:0]  confirmations;
        logic        conflict_flag;
        logic        first_arrival;
    } result_t;

    typedef struct packed {
        logic [1:0]  lane;
        logic [31:0] asset;
        logic [63:0] seq;
        logic [63:0] xtime;
        logic [63:0] rtime;
        logic [63:0] price;
        logic [63:0] size;
        logic [7:0]  side;
    } event_t;

    function automatic logic pos_finite(input logic [63:0] b);
        pos_finite = !b[63] && (b[62:52] != 11'h7FF) && (b != 64'd0);
    endfunction
endpackage

### design/rffag_slot_mem.sv
// Slot table: synchronous memory, one write and one registered read port.
module rffag_slot_mem #(
    parameter int SLOT_COUNT = 1024,
    parameter int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic                  clk,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output rffag_pkg::slot_t      rd_data,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  rffag_pkg::slot_t      wr_data
);
    rffag_pkg::slot_t mem [SLOT_COUNT];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

### design/rffag_classify.sv
// Classifies a looked-up event and builds the slot write-back and result.
module rffag_classify (
    input  rffag_pkg::event_t  ev,
    input  logic               hit_valid,
    input  rffag_pkg::slot_t   slot,
    input  logic [63:0]        watermark,
    output rffag_pkg::result_t res,
    output logic               wr_en,
    output rffag_pkg::slot_t   wr_data,
    output logic               wm_load
);
    logic [2:0] bit_l;
    logic       hit;
    logic       same;
    logic       early;

    always_comb
    begin
        bit_l   = 3'(1) << ev.lane;
        hit     = hit_valid && (slot.seq == ev.seq);
        same    = slot.asset == ev.asset && slot.xtime == ev.xtime
               && slot.price == ev.price && slot.size == ev.size && slot.side == ev.side;
        early   = $signed(ev.rtime) < $signed(slot.ftime);
        res     = '0;
        wr_en   = 1'b0;
        wm_load = 1'b0;
        wr_data = slot;
        res.out_sequence = ev.seq;
        if (!hit)
        begin
            if (watermark != 64'd0 && ev.seq <= watermark)
            begin
                res.disposition = rffag_pkg::DISP_STALE;
            end
            else
            begin
                wm_load          = 1'b1;
                wr_en            = 1'b1;
                wr_data.used     = 1'b1;
                wr_data.seq      = ev.seq;
                wr_data.asset    = ev.asset;
                wr_data.xtime    = ev.xtime;
                wr_data.ftime    = ev.rtime;
                wr_data.price    = ev.price;
                wr_data.size     = ev.size;
                wr_data.side     = ev.side;
                wr_data.lanes    = bit_l;
                wr_data.confirms = 2'd0;
                wr_data.conflict = 1'b0;
                res.disposition  = rffag_pkg::DISP_FIRST;
                res.first_time   = ev.rtime;
                res.lanes_seen   = bit_l;
                res.first_arrival = 1'b1;
            end
        end
        else
        begin
            res.first_time    = slot.ftime;
            res.lanes_seen    = slot.lanes;
            res.confirmations = slot.confirms;
            res.conflict_flag = slot.conflict;
            if (!same || early)
            begin
                wr_en             = 1'b1;
                wr_data.conflict  = 1'b1;
                res.disposition   = rffag_pkg::DISP_CONFLICT;
                res.conflict_flag = 1'b1;
            end
            else if ((slot.lanes & bit_l) != 3'd0)
            begin
                res.disposition = rffag_pkg::DISP_DUP;
            end
            else
            begin
                wr_en          = 1'b1;
                wr_data.lanes  = slot.lanes | bit_l;
                if (slot.confirms < rffag_pkg::CONFIRM_MAX)
                begin
                    wr_data.confirms = slot.confirms + 2'd1;
                end
                res.disposition   = rffag_pkg::DISP_CONFIRM;
                res.confirm_time  = ev.rtime;
                res.lanes_seen    = wr_data.lanes;
                res.confirmations = wr_data.confirms;
            end
        end
    end
endmodule

### design/redundant_feed_first_arrival_gate.sv
// Top level of the redundant-feed first-arrival gate.
// After reset the slot table is cleared slot by slot with s_tready low. A request is checked and its
// slot read in the cycle it is accepted; the next cycle classifies it and writes the slot back,
// and its result goes to the output register, or to the skid register while the output register
// holds a result not yet taken. A write-back to the slot that the next request reads is forwarded
// past the memory. Output and skid registers hold at most two results; s_tready drops while the
// skid register is full or while both the classify stage and the output register hold a request,
// so a new request is taken while the one before it is classified only if the output is free.
`include "assert_macros.svh"
module redundant_feed_first_arrival_gate #(
    parameter int SLOT_COUNT = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [1:0]   s_tuser,   // lane
    // venue, event_kind, asset_id, sequence_req, exchange_time, receive_time,
    // price_bits, size_bits, side, health_flags, 5 zero bits
    input  logic [383:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // disposition, out_sequence, first_time, confirm_time, lanes_seen,
    // confirmations, conflict_flag, first_arrival, 6 zero bits
    output logic [207:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [7:0]   cfg_data
);
    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic [7:0]  venue_reg, kind_reg;
    logic [63:0] wm_reg;

    // slot table clearing after reset
    logic                clr_busy_reg;
    logic [AW-1:0]       clr_addr_reg;

    // stage 1
    logic                s1_v_reg, s1_ok_reg;
    rffag_pkg::event_t   s1_ev_reg;
    logic [AW-1:0]       s1_idx_reg;
    logic                fw_hit_reg;
    rffag_pkg::slot_t    fw_data_reg;

    // output + skid
    logic                o_v_reg, k_v_reg;
    rffag_pkg::result_t  o_reg, k_reg;

    rffag_pkg::event_t   ev;
    logic                ok, acc;
    logic [AW-1:0]       idx;
    rffag_pkg::slot_t    rd_data, slot, wr_data;
    rffag_pkg::result_t  res, res_f;
    logic                wr_en, wm_load, hv;
    logic                mem_wr_en;
    logic [AW-1:0]       mem_wr_addr;
    rffag_pkg::slot_t    mem_wr_data;

    assign cfg_ready = 1'b1;
    assign s_tready  = !clr_busy_reg && !k_v_reg && !(o_v_reg && s1_v_reg);
    assign acc       = s_tvalid && s_tready;

    always_comb
    begin
        ev.lane  = s_tuser;
        ev.asset = s_tdata[47:16];
        ev.seq   = s_tdata[111:48];
        ev.xtime = s_tdata[175:112];
        ev.rtime = s_tdata[239:176];
        ev.price = s_tdata[303:240];
        ev.size  = s_tdata[367:304];
        ev.side  = s_tdata[375:368];
        ok = s_tuser != rffag_pkg::LANE_BAD && s_tdata[7:0] == venue_reg
          && s_tdata[15:8] == kind_reg && ev.asset != 32'd0 && ev.seq != 64'd0
          && !ev.xtime[63] && ev.xtime != 64'd0 && !ev.rtime[63] && ev.rtime != 64'd0
          && rffag_pkg::pos_finite(ev.price) && rffag_pkg::pos_finite(ev.size)
          && (ev.side == rffag_pkg::SIDE_BUY || ev.side == rffag_pkg::SIDE_SELL)
          && s_tdata[378:376] == rffag_pkg::HEALTH_OK;
        idx = AW'(ev.seq & 64'(SLOT_COUNT - 1));
    end

    always_comb
    begin
        if (clr_busy_reg)
        begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr_reg;
            mem_wr_data = '0;
        end
        else
        begin
            mem_wr_en   = wr_en && s1_v_reg && s1_ok_reg;
            mem_wr_addr = s1_idx_reg;
            mem_wr_data = wr_data;
        end
    end

    rffag_slot_mem #(.SLOT_COUNT(SLOT_COUNT), .AW(AW)) u_mem (
        .clk(clk), .rd_en(acc), .rd_addr(idx), .rd_data(rd_data),
        .wr_en(mem_wr_en), .wr_addr(mem_wr_addr), .wr_data(mem_wr_data)
    );

    always_comb
    begin
        slot = fw_hit_reg ? fw_data_reg : rd_data;
        hv   = slot.used;
    end

    rffag_classify u_cls (
        .ev(s1_ev_reg), .hit_valid(hv), .slot(slot), .watermark(wm_reg),
        .res(res), .wr_en(wr_en), .wr_data(wr_data), .wm_load(wm_load)
    );

    assign res_f = s1_ok_reg ? res : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            venue_reg    <= '0;
            kind_reg     <= '0;
            wm_reg       <= '0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            s1_v_reg     <= 1'b0;
            s1_ok_reg    <= 1'b0;
            fw_hit_reg   <= 1'b0;
            o_v_reg      <= 1'b0;
            k_v_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == rffag_pkg::REG_VENUE)
                begin
                    venue_reg <= cfg_data;
                end
                else
                begin
                    kind_reg <= cfg_data;
                end
            end
            if (clr_busy_reg)
            begin
                if (clr_addr_reg == AW'(SLOT_COUNT - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (s1_v_reg && s1_ok_reg && wm_load)
            begin
                wm_reg <= s1_ev_reg.seq;
            end
            s1_v_reg <= acc;
            if (acc)
            begin
                s1_ok_reg  <= ok;
                s1_ev_reg  <= ev;
                s1_idx_reg <= idx;
                fw_hit_reg <= s1_v_reg && s1_ok_reg && wr_en && s1_idx_reg == idx;
                fw_data_reg <= wr_data;
            end
            // output register with skid
            if (s1_v_reg)
            begin
                if (!o_v_reg || m_tready)
                begin
                    o_v_reg <= 1'b1;
                    o_reg   <= res_f;
                end
                else
                begin
                    k_v_reg <= 1'b1;
                    k_reg   <= res_f;
                end
            end
            else if (m_tready && o_v_reg)
            begin
                o_v_reg <= k_v_reg;
                o_reg   <= k_reg;
                k_v_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = o_v_reg;
    assign m_tdata  = {6'd0, o_reg.first_arrival, o_reg.conflict_flag, o_reg.confirmations,
                       o_reg.lanes_seen, o_reg.confirm_time, o_reg.first_time,
                       o_reg.out_sequence, o_reg.disposition};

    `ASSERT_IMP(a_skid_only_stalled, clk, rst_n, k_v_reg, o_v_reg, "skid full while output empty")
    `ASSERT_NEXT(a_no_accept_full, clk, rst_n, k_v_reg && !m_tready, !s1_v_reg, "accepted into full skid")
    `ASSERT_IMP(a_reject_zero, clk, rst_n, s1_v_reg && !s1_ok_reg, res_f == '0, "reject not zero")
    `ASSERT_IMP(a_no_accept_clear, clk, rst_n, clr_busy_reg, !acc, "request taken while clearing")
endmodule

### bench/redundant_feed_first_arrival_gate_tb.sv
// Self-checking bench for the redundant-feed first-arrival gate: directed table, then random.
`timescale 1ns / 1ps
module redundant_feed_first_arrival_gate_tb;

    localparam int SLOTS       = 1024;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [1:0]  lane;
        logic [7:0]  venue;
        logic [7:0]  kind;
        logic [31:0] asset;
        logic [63:0] seq;
        logic [63:0] xtime;
        logic [63:0] rtime;
        logic [63:0] price;
        logic [63:0] size;
        logic [7:0]  side;
        logic [2:0]  health;
    } trade_t;

    typedef struct {
        logic [2:0]  disp;
        logic [63:0] seq;
        logic [63:0] first_t;
        logic [63:0] confirm_t;
        logic [2:0]  lanes;
        logic [1:0]  confirms;
        logic        conflict;
        logic        emit;
    } verdict_t;

    typedef struct {
        logic        used;
        logic [63:0] seq;
        logic [31:0] asset;
        logic [63:0] xtime;
        logic [63:0] ftime;
        logic [63:0] price;
        logic [63:0] size;
        logic [7:0]  side;
        logic [2:0]  lanes;
        logic [1:0]  confirms;
        logic        conflict;
    } entry_t;

    typedef struct {
        trade_t ev;
        bit     must_reject;
    } row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [1:0]   s_tuser;
    logic [383:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [207:0] m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic         cfg_index;
    logic [7:0]   cfg_data;

    redundant_feed_first_arrival_gate dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    entry_t      slot_tab [SLOTS];
    logic [63:0] watermark;
    logic [7:0]  want_venue;
    logic [7:0]  want_kind;
    verdict_t    pending_q [$];
    bit          typed_reject_q [$];
    trade_t      recent_q [$];
    row_t        rows [$];

    int  errors;
    int  cycles = 0;
    int  sent;
    int  checked;
    int  disp_seen [6];
    bit  quiet;
    bit  hold_req;
    bit  holding;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_q.size());
            $display("redundant_feed_first_arrival_gate_tb: errors");
            $finish;
        end
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
        errors++;
    endtask

    function automatic logic [383:0] pack_trade(input trade_t e);
        return {5'b0, e.health, e.side, e.size, e.price, e.rtime, e.xtime, e.seq,
                e.asset, e.kind, e.venue};
    endfunction

    function automatic bit good_double(input logic [63:0] b);
        return !b[63] && b[62:52] != 11'h7FF && b != 64'd0;
    endfunction

    function automatic bit good_time(input logic [63:0] t);
        return !t[63] && t != 64'd0;
    endfunction

    // classify one accepted trade and update the slot table
    function automatic verdict_t classify(input trade_t e);
        verdict_t    v;
        logic [9:0]  idx;
        logic [2:0]  bitm;
        bit          same;
        v = '{default: '0};
        if (e.lane == rffag_pkg::LANE_BAD || e.venue != want_venue || e.kind != want_kind
            || e.asset == 32'd0 || e.seq == 64'd0 || !good_time(e.xtime)
            || !good_time(e.rtime) || !good_double(e.price) || !good_double(e.size)
            || !(e.side == rffag_pkg::SIDE_BUY || e.side == rffag_pkg::SIDE_SELL)
            || e.health != rffag_pkg::HEALTH_OK)
        begin
            v.disp = rffag_pkg::DISP_REJECT;
            return v;
        end
        idx  = e.seq[9:0];
        bitm = 3'b001 << e.lane;
        v.seq = e.seq;
        if (!slot_tab[idx].used || slot_tab[idx].seq != e.seq)
        begin
            if (watermark != 64'd0 && e.seq <= watermark)
            begin
                v.disp = rffag_pkg::DISP_STALE;
                return v;
            end
            watermark = e.seq;
            slot_tab[idx] = '{1'b1, e.seq, e.asset, e.xtime, e.rtime, e.price, e.size,
                              e.side, bitm, 2'd0, 1'b0};
            v.disp    = rffag_pkg::DISP_FIRST;
            v.first_t = e.rtime;
            v.lanes   = bitm;
            v.emit    = 1'b1;
            return v;
        end
        v.first_t  = slot_tab[idx].ftime;
        v.lanes    = slot_tab[idx].lanes;
        v.confirms = slot_tab[idx].confirms;
        v.conflict = slot_tab[idx].conflict;
        same = slot_tab[idx].asset == e.asset && slot_tab[idx].xtime == e.xtime
            && slot_tab[idx].price == e.price && slot_tab[idx].size == e.size
            && slot_tab[idx].side == e.side;
        if (!same || $signed(e.rtime) < $signed(slot_tab[idx].ftime))
        begin
            slot_tab[idx].conflict = 1'b1;
            v.disp     = rffag_pkg::DISP_CONFLICT;
            v.conflict = 1'b1;
            return v;
        end
        if ((slot_tab[idx].lanes & bitm) != 3'd0)
        begin
            v.disp = rffag_pkg::DISP_DUP;
            return v;
        end
        slot_tab[idx].lanes = slot_tab[idx].lanes | bitm;
        if (slot_tab[idx].confirms < rffag_pkg::CONFIRM_MAX)
            slot_tab[idx].confirms = slot_tab[idx].confirms + 2'd1;
        v.disp      = rffag_pkg::DISP_CONFIRM;
        v.confirm_t = e.rtime;
        v.lanes     = slot_tab[idx].lanes;
        v.confirms  = slot_tab[idx].confirms;
        return v;
    endfunction

    // request and result monitor
    always @(posedge clk)
    begin
        verdict_t want;
        verdict_t got;
        trade_t   e;
        bit       typed;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == rffag_pkg::REG_VENUE)
                    want_venue = cfg_data;
                else
                    want_kind = cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                e.lane   = s_tuser;
                {e.health, e.side, e.size, e.price, e.rtime, e.xtime, e.seq, e.asset,
                 e.kind, e.venue} = s_tdata[378:0];
                want  = classify(e);
                typed = typed_reject_q.pop_front();
                if (typed && want.disp != rffag_pkg::DISP_REJECT)
                    report("predicted disposition of a bad request", 64'(want.disp),
                           64'(rffag_pkg::DISP_REJECT));
                if (typed)
                    want = '{default: '0};
                pending_q.push_back(want);
            end
            if (m_tvalid && m_tready)
            begin
                got.disp      = m_tdata[2:0];
                got.seq       = m_tdata[66:3];
                got.first_t   = m_tdata[130:67];
                got.confirm_t = m_tdata[194:131];
                got.lanes     = m_tdata[197:195];
                got.confirms  = m_tdata[199:198];
                got.conflict  = m_tdata[200];
                got.emit      = m_tdata[201];
                if (pending_q.size() == 0)
                    report("unexpected result, disposition", 64'(got.disp), 64'd0);
                else
                begin
                    want = pending_q.pop_front();
                    checked++;
                    if (got.disp <= rffag_pkg::DISP_CONFIRM)
                        disp_seen[got.disp]++;
                    if (got.disp != want.disp)
                        report("disposition", 64'(got.disp), 64'(want.disp));
                    if (got.seq != want.seq) report("out_sequence", got.seq, want.seq);
                    if (got.first_t != want.first_t)
                        report("first_time", got.first_t, want.first_t);
                    if (got.confirm_t != want.confirm_t)
                        report("confirm_time", got.confirm_t, want.confirm_t);
                    if (got.lanes != want.lanes)
                        report("lanes_seen", 64'(got.lanes), 64'(want.lanes));
                    if (got.confirms != want.confirms)
                        report("confirmations", 64'(got.confirms), 64'(want.confirms));
                    if (got.conflict != want.conflict)
                        report("conflict_flag", 64'(got.conflict), 64'(want.conflict));
                    if (got.emit != want.emit)
                        report("first_arrival", 64'(got.emit), 64'(want.emit));
                end
            end
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin
        int n;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                holding  = 1'b1;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                holding  = 1'b0;
                m_tready = 1'b1;
            end
            else if (quiet)
                m_tready = 1'b1;
            else
            begin
                m_tready = ($urandom_range(0, 3) != 0);
                n = $urandom_range(1, 16);
                repeat (n - 1) @(negedge clk);
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_time();
        logic [63:0] t;
        t = rand64() >> ($urandom_range(0, 1) ? 0 : $urandom_range(8, 40));
        t[63] = 1'b0;
        return (t == 64'd0) ? 64'd1 : t;
    endfunction

    function automatic logic [63:0] rand_double();
        logic [63:0] r;
        logic [63:0] b;
        r = rand64();
        b = {1'b0, 11'($urandom_range(0, 2046)), r[51:0]};
        return (b == 64'd0) ? 64'd1 : b;
    endfunction

    function automatic trade_t good_trade(input logic [63:0] seq, input logic [1:0] lane);
        trade_t e;
        e.lane   = lane;
        e.venue  = want_venue;
        e.kind   = want_kind;
        e.asset  = $urandom;
        if (e.asset == 32'd0) e.asset = 32'd7;
        e.seq    = seq;
        e.xtime  = rand_time();
        e.rtime  = rand_time();
        e.price  = rand_double();
        e.size   = rand_double();
        e.side   = $urandom_range(0, 1) ? rffag_pkg::SIDE_BUY : rffag_pkg::SIDE_SELL;
        e.health = rffag_pkg::HEALTH_OK;
        return e;
    endfunction

    task automatic send(input trade_t e, input bit must_reject);
        int n;
        if (!quiet && !hold_req && $urandom_range(0, 4) == 0)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
            n = $urandom_range(1, 16);
            repeat (n - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = e.lane;
        s_tdata  = pack_trade(e);
        typed_reject_q.push_back(must_reject);
        do @(posedge clk); while (!(s_tvalid && s_tready));
        sent++;
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic make_random(output trade_t e);
        int           r;
        int           k;
        trade_t       p;
        logic [63:0]  w;
        logic [415:0] junk;
        r = $urandom_range(0, 99);
        if (r >= 35 && r < 80 && recent_q.size() != 0)
        begin
            p = recent_q[$urandom_range(0, recent_q.size() - 1)];
            e = p;
            e.lane  = 2'($urandom_range(0, 2));
            e.rtime = p.rtime + 64'($urandom_range(0, 50));
            if (r >= 70)
            begin
                k = $urandom_range(0, 5);
                case (k)
                    0: e.asset = p.asset ^ (32'd1 << $urandom_range(0, 31));
                    1: e.xtime = p.xtime ^ 64'd1;
                    2: e.price = p.price ^ 64'd1;
                    3: e.size  = p.size ^ 64'd2;
                    4: e.side  = (p.side == rffag_pkg::SIDE_BUY) ? rffag_pkg::SIDE_SELL
                                                                 : rffag_pkg::SIDE_BUY;
                    default: e.rtime = p.rtime - 64'd1;
                endcase
            end
        end
        else if (r < 80)
        begin
            e = good_trade(watermark + 64'($urandom_range(1, (r < 5) ? 1500 : 3)),
                           2'($urandom_range(0, 2)));
            recent_q.push_back(e);
            if (recent_q.size() > 24)
                void'(recent_q.pop_front());
        end
        else if (r < 88)
            e = good_trade((watermark > 2000) ? watermark - 64'($urandom_range(1, 2000))
                                              : 64'd1,
                           2'($urandom_range(0, 2)));
        else if (r < 94)
        begin
            junk = {$urandom, rand64(), rand64(), rand64(), rand64(), rand64(), rand64()};
            {e.health, e.side, e.size, e.price, e.rtime, e.xtime, e.seq, e.asset, e.kind,
             e.venue} = junk[378:0];
            e.lane = 2'($urandom_range(0, 3));
        end
        else
        begin
            e = good_trade(watermark + 64'd1, 2'($urandom_range(0, 2)));
            w = rand64();
            k = $urandom_range(0, 5);
            case (k)
                0: e.lane   = rffag_pkg::LANE_BAD;
                1: e.price  = {1'b1, w[62:0]};
                2: e.size   = {1'b0, 11'h7FF, w[51:0]};
                3: e.side   = 8'($urandom_range(2, 254));
                4: e.health = 3'($urandom_range(0, 3));
                default: e.rtime = {1'b1, w[62:0]};
            endcase
        end
    endtask

    initial
    begin
        trade_t      e;
        trade_t      g;
        logic [7:0]  venues [4];
        logic [7:0]  kinds [4];
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = '0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = rffag_pkg::REG_VENUE;
        cfg_data  = '0;
        errors = 0; sent = 0; checked = 0;
        quiet = 1'b0; hold_req = 1'b0; holding = 1'b0;
        watermark = '0; want_venue = '0; want_kind = '0;
        foreach (slot_tab[i]) slot_tab[i].used = 1'b0;
        foreach (disp_seen[i]) disp_seen[i] = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table under reset register values
        g = good_trade(64'd5, 2'd0);
        rows.push_back('{g, 1'b0});
        e = g; e.lane = 2'd1; rows.push_back('{e, 1'b0});
        e = g; e.lane = 2'd2; e.rtime = g.rtime + 64'd9; rows.push_back('{e, 1'b0});
        e = g; rows.push_back('{e, 1'b0});
        e = g; e.lane = 2'd1; e.price = g.price ^ 64'd1; rows.push_back('{e, 1'b0});
        e = g; e.lane = 2'd2; e.rtime = g.rtime - 64'd1; rows.push_back('{e, 1'b0});
        e = good_trade(64'd3, 2'd1); rows.push_back('{e, 1'b0});
        e = good_trade(64'd1029, 2'd2);
        e.asset = 32'hFFFF_FFFF; e.price = 64'h7FEF_FFFF_FFFF_FFFF; e.size = 64'd1;
        e.xtime = 64'd1; e.rtime = 64'h7FFF_FFFF_FFFF_FFFF; e.side = rffag_pkg::SIDE_SELL;
        rows.push_back('{e, 1'b0});
        e = g; e.lane = 2'd1; rows.push_back('{e, 1'b0});
        e = good_trade(64'd2000, rffag_pkg::LANE_BAD); rows.push_back('{e, 1'b1});
        e = good_trade(64'd0, 2'd0); rows.push_back('{e, 1'b1});
        e = good_trade(64'd2001, 2'd0); e.asset = 32'd0; rows.push_back('{e, 1'b1});
        e = good_trade(64'd2002, 2'd0); e.venue = 8'hFF; rows.push_back('{e, 1'b1});
        e = good_trade(64'd2003, 2'd0); e.kind = 8'd1; rows.push_back('{e, 1'b1});
        e = good_trade(64'd2004, 2'd0); e.xtime = 64'd0; rows.push_back('{e, 1'b1});
        e = good_trade(64'd2005, 2'd0); e.rtime = 64'h8000_0000_0000_0000;
        rows.push_back('{e, 1'b1});
        e = good_trade(64'd2006, 2'd0); e.price = 64'h7FF0_0000_0000_0000;
        rows.push_back('{e, 1'b1});
        e = good_trade(64'd2007, 2'd0); e.price = 64'h7FF8_0000_0000_0001;
        rows.push_back('{e, 1'b1});
        e = good_trade(64'd2008, 2'd0); e.price = 64'hBFF0_0000_0000_0000;
        rows.push_back('{e, 1'b1});
        e = good_trade(64'd2009, 2'd0); e.size = 64'd0; rows.push_back('{e, 1'b1});
        e = good_trade(64'd2010, 2'd0); e.side = 8'd0; rows.push_back('{e, 1'b1});
        e = good_trade(64'd2011, 2'd0); e.side = 8'h80; rows.push_back('{e, 1'b1});
        e = good_trade(64'd2012, 2'd0); e.health = 3'b000; rows.push_back('{e, 1'b1});
        e = good_trade(64'd2013, 2'd0); e.health = 3'b101; rows.push_back('{e, 1'b1});
        e = good_trade(64'd2014, 2'd0); e.side = 8'h7F; rows.push_back('{e, 1'b1});
        foreach (rows[i])
            send(rows[i].ev, rows[i].must_reject);
        drain();

        // random phases, each under its own register setting
        venues = '{8'hFF, 8'($urandom), 8'h00, 8'($urandom)};
        kinds  = '{8'hFF, 8'($urandom), 8'h00, 8'($urandom)};
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(rffag_pkg::REG_VENUE, venues[ph]);
            write_reg(rffag_pkg::REG_KIND, kinds[ph]);
            recent_q.delete();
            for (int i = 0; i < 256; i++)
            begin
                if (ph == 0 && i == 40)
                    hold_req = 1'b1;
                if (ph == 3 && i == 128)
                    quiet = 1'b1;
                make_random(e);
                send(e, 1'b0);
            end
            drain();
        end
        while (hold_req || holding) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("%0d requests over five register settings, %0d results checked", sent, checked);
        $display("rejected %0d first %0d stale %0d conflict %0d duplicate %0d confirm %0d",
                 disp_seen[0], disp_seen[1], disp_seen[2], disp_seen[3], disp_seen[4],
                 disp_seen[5]);
        if (errors == 0 && pending_q.size() == 0)
            $display("redundant_feed_first_arrival_gate_tb: clean");
        else
            $display("redundant_feed_first_arrival_gate_tb: errors");
        $finish;
    end
endmodule

### filelist.f
+incdir+design
design/rffag_pkg.sv
design/rffag_slot_mem.sv
design/rffag_classify.sv
design/redundant_feed_first_arrival_gate.sv
bench/redundant_feed_first_arrival_gate_tb.sv
